[rtl/smes_pkg.sv]
`default_nettype none
package smes_pkg;

    localparam int unsigned COORD_W    = 15;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 8'd1;

    localparam logic [COORD_W-1:0] BOUND_RESET = 15'h7FFF;

    typedef struct packed {
        logic               vld;
        logic               act;
        logic [1:0]         op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               found;
        logic               free_seen;
    } t_tok;

    typedef struct packed {
        logic done;
        logic commit;
    } t_fin;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
        logic               full;
    } t_res;

endpackage
`default_nettype wire

[rtl/smes_in_if.sv]
`default_nettype none
interface smes_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic signed [15:0] row;
    logic signed [15:0] column;
    logic [31:0]       value_in;

    modport source (output valid, output operation, output row, output column,
                    output value_in, input ready);
    modport sink   (input valid, input operation, input row, input column,
                    input value_in, output ready);
endinterface
`default_nettype wire

[rtl/smes_out_if.sv]
`default_nettype none
interface smes_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] value_out;
    logic        table_full;

    modport source (output valid, output ok, output value_out, output table_full,
                    input ready);
    modport sink   (input valid, input ok, input value_out, input table_full,
                    output ready);
endinterface
`default_nettype wire

[rtl/smes_cell.sv]
`default_nettype none
module smes_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  smes_pkg::t_tok  i_tok,
    input  smes_pkg::t_fin  i_fin,
    output smes_pkg::t_tok  o_tok
);

    logic                          r_valid;
    logic                          r_pend;
    logic [smes_pkg::COORD_W-1:0]  r_row;
    logic [smes_pkg::COORD_W-1:0]  r_col;
    logic [smes_pkg::VALUE_W-1:0]  r_value;
    smes_pkg::t_tok                r_tok;
    smes_pkg::t_tok                n_tok;
    logic                          w_live;
    logic                          w_hit;
    logic                          w_free;

    always_comb begin
        w_live = i_tok.vld & i_tok.act;
        w_hit  = w_live & r_valid & (r_row == i_tok.row) & (r_col == i_tok.col);
        w_free = w_live & (i_tok.op == smes_pkg::OP_INSERT) & ~r_valid & ~i_tok.free_seen;
        n_tok  = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            if (i_tok.op == smes_pkg::OP_READ) begin
                n_tok.value = r_value;
            end
        end
        if (w_free) begin
            n_tok.free_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pend    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_hit && i_tok.op == smes_pkg::OP_INSERT) begin
                r_value <= i_tok.value;
            end
            if (w_hit && i_tok.op == smes_pkg::OP_DELETE) begin
                r_valid <= 1'b0;
            end
            if (w_free) begin
                r_pend  <= 1'b1;
                r_row   <= i_tok.row;
                r_col   <= i_tok.col;
                r_value <= i_tok.value;
            end
            if (i_fin.done) begin
                r_pend <= 1'b0;
                if (r_pend && i_fin.commit) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[rtl/sparse_matrix_entry_store_top.sv]
// Sparse matrix element store keyed by (row, column).
// Input channel i_in carries operation (insert/update, read, delete), row,
// column and value_in; output channel o_out returns ok, value_out and
// table_full, one result per accepted item, in order.
// Configuration: i_cfg_we with i_cfg_idx 0 sets num_rows, 1 sets num_cols;
// other indexes are ignored. Write only while no item is in flight.
// Each request walks a row of CAPACITY cells, one cell per cycle; each cell
// holds one entry and compares its key locally. A new element takes the
// lowest free cell, which is confirmed when the request leaves the row.
// One item is in the row at a time: a new item is accepted only after the
// previous one has left the row.
// A result register plus one skid entry let the next item enter while a
// result waits; a stalled receiver blocks new items once both are full.
// Reset clears all entries, the in-flight request and both result slots,
// and sets both bounds to 32767. No clearing pass is needed.
`default_nettype none
module sparse_matrix_entry_store_top #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [smes_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [smes_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    smes_in_if.sink                           i_in,
    smes_out_if.source                        o_out
);

    logic [smes_pkg::COORD_W-1:0] r_num_rows;
    logic [smes_pkg::COORD_W-1:0] r_num_cols;
    logic                         r_busy;
    logic                         r_out_vld;
    smes_pkg::t_res               r_out;
    logic                         r_skid_vld;
    smes_pkg::t_res               r_skid;

    smes_pkg::t_tok               w_head;
    smes_pkg::t_tok               w_tok [0:CAPACITY];
    logic [CAPACITY-1:0]          w_tok_vld;
    smes_pkg::t_tok               w_last;
    smes_pkg::t_fin               w_fin;
    smes_pkg::t_res               w_res;
    logic                         w_acc;
    logic                         w_take;
    logic                         w_new;

    assign i_in.ready = ~r_busy & ~r_skid_vld;
    assign w_acc      = i_in.valid & i_in.ready;
    assign w_take     = r_out_vld & o_out.ready;

    always_comb begin
        w_head.vld       = w_acc;
        w_head.act       = ~i_in.row[15] & ~i_in.column[15]
                           & (i_in.row[14:0] < r_num_rows)
                           & (i_in.column[14:0] < r_num_cols)
                           & (i_in.operation != smes_pkg::OP_UNUSED);
        w_head.op        = i_in.operation;
        w_head.row       = i_in.row[14:0];
        w_head.col       = i_in.column[14:0];
        w_head.value     = i_in.value_in;
        w_head.found     = 1'b0;
        w_head.free_seen = 1'b0;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        smes_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_fin   (w_fin),
            .o_tok   (w_tok[g+1])
        );
        assign w_tok_vld[g] = w_tok[g+1].vld;
    end

    assign w_last = w_tok[CAPACITY];
    assign w_new  = w_last.act & (w_last.op == smes_pkg::OP_INSERT) & ~w_last.found;

    always_comb begin
        w_fin.done   = w_last.vld;
        w_fin.commit = w_new & w_last.free_seen;
        w_res.full   = w_new & ~w_last.free_seen;
        w_res.ok     = w_last.found | (w_new & w_last.free_seen);
        w_res.value  = (w_last.found && w_last.op == smes_pkg::OP_READ) ?
                       w_last.value : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= smes_pkg::BOUND_RESET;
            r_num_cols <= smes_pkg::BOUND_RESET;
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == smes_pkg::CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == smes_pkg::CFG_NUM_COLS) begin
                r_num_cols <= i_cfg_data;
            end
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_last.vld) begin
                r_busy <= 1'b0;
            end
            if (w_last.vld) begin
                if (!r_out_vld || w_take) begin
                    r_out     <= w_res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid     <= w_res;
                    r_skid_vld <= 1'b1;
                end
            end else if (w_take) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.ok         = r_out.ok;
    assign o_out.value_out  = r_out.value;
    assign o_out.table_full = r_out.full;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_vld) <= 1)
        else $error("more than one request in the cell row");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    a_insert_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last.vld && w_last.act && w_last.op == smes_pkg::OP_INSERT)
        |-> (w_res.ok != w_res.full))
        else $error("insert neither stored nor flagged full");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("request accepted without marking busy");

    a_end_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.vld |-> (r_busy && !r_skid_vld))
        else $error("request left the row with no room for its result");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
`default_nettype none
module testbench;

    localparam int unsigned ENTRIES      = 256;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 1500;
    localparam int unsigned DRAIN_CYCLES = ENTRIES + 64;

    localparam logic [smes_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
    localparam logic [smes_pkg::CFG_IDX_W-1:0] CFG_LAST  = 8'hFF;
    localparam logic [smes_pkg::COORD_W-1:0]   BOUND_MAX = 15'h7FFF;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] row;
        logic signed [15:0] column;
        logic [31:0]        value;
    } t_store_req;

    class element_store_scoreboard;
        logic [smes_pkg::COORD_W-1:0] row_bound;
        logic [smes_pkg::COORD_W-1:0] col_bound;
        bit                           slot_used  [ENTRIES];
        logic [smes_pkg::COORD_W-1:0] slot_row   [ENTRIES];
        logic [smes_pkg::COORD_W-1:0] slot_col   [ENTRIES];
        logic [smes_pkg::VALUE_W-1:0] slot_value [ENTRIES];
        smes_pkg::t_res               expected_responses [$];
        int                           n_checked;
        int                           n_errors;
        int                           n_read_hits;
        int                           n_full;

        function new();
            row_bound = smes_pkg::BOUND_RESET;
            col_bound = smes_pkg::BOUND_RESET;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            n_checked   = 0;
            n_errors    = 0;
            n_read_hits = 0;
            n_full      = 0;
        endfunction

        function void write_register(logic [smes_pkg::CFG_IDX_W-1:0] idx,
                                     logic [smes_pkg::CFG_DATA_W-1:0] data);
            if (idx == smes_pkg::CFG_NUM_ROWS) begin
                row_bound = data;
            end else if (idx == smes_pkg::CFG_NUM_COLS) begin
                col_bound = data;
            end
        endfunction

        function smes_pkg::t_res predict_response(t_store_req req);
            smes_pkg::t_res rsp;
            int   hit;
            int   spare;
            int   i;
            logic in_range;
            rsp   = '0;
            hit   = ENTRIES;
            spare = ENTRIES;
            in_range = !req.row[15] && !req.column[15] &&
                       req.row[smes_pkg::COORD_W-1:0] < row_bound &&
                       req.column[smes_pkg::COORD_W-1:0] < col_bound;
            if (!in_range || req.op == smes_pkg::OP_UNUSED) return rsp;
            // scan downward so the lowest match and lowest free slot win
            for (i = ENTRIES - 1; i >= 0; i--) begin
                if (slot_used[i] && slot_row[i] == req.row[smes_pkg::COORD_W-1:0] &&
                    slot_col[i] == req.column[smes_pkg::COORD_W-1:0]) hit = i;
                if (!slot_used[i]) spare = i;
            end
            case (req.op)
                smes_pkg::OP_INSERT: begin
                    if (hit != ENTRIES) begin
                        slot_value[hit] = req.value;
                        rsp.ok = 1'b1;
                    end else if (spare != ENTRIES) begin
                        slot_used[spare]  = 1'b1;
                        slot_row[spare]   = req.row[smes_pkg::COORD_W-1:0];
                        slot_col[spare]   = req.column[smes_pkg::COORD_W-1:0];
                        slot_value[spare] = req.value;
                        rsp.ok = 1'b1;
                    end else begin
                        rsp.full = 1'b1;
                    end
                end
                smes_pkg::OP_READ: begin
                    if (hit != ENTRIES) begin
                        rsp.ok    = 1'b1;
                        rsp.value = slot_value[hit];
                    end
                end
                smes_pkg::OP_DELETE: begin
                    if (hit != ENTRIES) begin
                        slot_used[hit] = 1'b0;
                        rsp.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            return rsp;
        endfunction

        function void note_request(t_store_req req);
            expected_responses.push_back(predict_response(req));
        endfunction

        function void check_response(logic ok, logic [smes_pkg::VALUE_W-1:0] value,
                                     logic full);
            smes_pkg::t_res want;
            if (expected_responses.size() == 0) begin
                $error("result with nothing outstanding: ok=%0d value_out=%h table_full=%0d",
                       ok, value, full);
                n_errors++;
                return;
            end
            want = expected_responses.pop_front();
            n_checked++;
            if (ok !== want.ok) begin
                $error("ok: expected %0d, actual %0d", want.ok, ok);
                n_errors++;
            end
            if (value !== want.value) begin
                $error("value_out: expected %h, actual %h", want.value, value);
                n_errors++;
            end
            if (full !== want.full) begin
                $error("table_full: expected %0d, actual %0d", want.full, full);
                n_errors++;
            end
            if (want.ok && want.value != '0) n_read_hits++;
            if (want.full) n_full++;
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [smes_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [smes_pkg::CFG_DATA_W-1:0] cfg_data;
    int unsigned                     cycle_count = 0;
    int                              n_settings = 0;
    bit                              src_burst = 1'b0;
    bit                              snk_burst = 1'b0;
    bit                              long_hold_done = 1'b0;

    element_store_scoreboard scb;

    smes_in_if  in_bus ();
    smes_out_if out_bus ();

    sparse_matrix_entry_store_top #(
        .CAPACITY (ENTRIES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_coord(int span);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return 16'(span);
        if (sel == 2) return 16'(-int'($urandom_range(1, 32768)));
        return 16'($urandom_range(0, span - 1));
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom;
    endfunction

    // entered and left just after a falling edge
    task automatic send_request(input logic [1:0] op, input logic signed [15:0] row,
                                input logic signed [15:0] column, input logic [31:0] value);
        t_store_req req;
        int         gap;
        req = '{op: op, row: row, column: column, value: value};
        if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op;
        in_bus.row       <= row;
        in_bus.column    <= column;
        in_bus.value_in  <= value;
        do @(posedge clk); while (!in_bus.ready);
        scb.note_request(req);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (scb.expected_responses.size() != 0) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [smes_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smes_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        scb.write_register(idx, data);
        @(negedge clk);
    endtask

    task automatic set_bounds(input logic [smes_pkg::COORD_W-1:0] rows,
                              input logic [smes_pkg::COORD_W-1:0] cols);
        wait_idle();
        write_cfg(smes_pkg::CFG_NUM_ROWS, rows);
        write_cfg(smes_pkg::CFG_NUM_COLS, cols);
        n_settings++;
    endtask

    task automatic random_requests(int count, int span, int w_ins, int w_read);
        int         roll;
        logic [1:0] op;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) op = smes_pkg::OP_UNUSED;
            else if (roll < 3 + w_ins) op = smes_pkg::OP_INSERT;
            else if (roll < 3 + w_ins + w_read) op = smes_pkg::OP_READ;
            else op = smes_pkg::OP_DELETE;
            send_request(op, pick_coord(span), pick_coord(span), pick_value());
        end
    endtask

    // walk count distinct keys row by row, reading back an earlier key after every eighth insert
    task automatic fill_keys(int count, int cols);
        int k;
        int j;
        for (k = 0; k < count; k++) begin
            send_request(smes_pkg::OP_INSERT, 16'(k / cols), 16'(k % cols), pick_value());
            if (k % 8 == 7) begin
                j = $urandom_range(0, k);
                send_request(smes_pkg::OP_READ, 16'(j / cols), 16'(j % cols), $urandom);
            end
        end
    endtask

    initial begin : result_sink
        int gap;
        out_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 49) == 0) snk_burst = !snk_burst;
            gap = snk_burst ? 0 : $urandom_range(0, 5);
            if (!long_hold_done && scb.n_checked >= 50) begin
                gap = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (gap != 0) begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge clk); while (!out_bus.valid);
            scb.check_response(out_bus.ok, out_bus.value_out, out_bus.table_full);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        scb = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_bus.valid     = 1'b0;
        in_bus.operation = smes_pkg::OP_INSERT;
        in_bus.row       = '0;
        in_bus.column    = '0;
        in_bus.value_in  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(smes_pkg::OP_INSERT, 16'sd0, 16'sd0, 32'h3F80_0000);
        send_request(smes_pkg::OP_INSERT, 16'sd32766, 16'sd32766, 32'hFFFF_FFFF);
        send_request(smes_pkg::OP_INSERT, 16'sd32766, 16'sd0, 32'h0000_0000);
        send_request(smes_pkg::OP_READ, 16'sd0, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_READ, 16'sd32766, 16'sd32766, 32'h0);
        send_request(smes_pkg::OP_READ, 16'sd32766, 16'sd0, 32'hFFFF_FFFF);
        send_request(smes_pkg::OP_READ, 16'sd1, 16'sd1, 32'h0);
        send_request(smes_pkg::OP_INSERT, 16'sd0, 16'sd0, 32'hA5A5_5A5A);
        send_request(smes_pkg::OP_READ, 16'sd0, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_INSERT, 16'sd32767, 16'sd0, 32'h1234_5678);
        send_request(smes_pkg::OP_INSERT, 16'sd0, 16'sd32767, 32'h1234_5678);
        send_request(smes_pkg::OP_INSERT, -16'sd1, 16'sd0, 32'h1234_5678);
        send_request(smes_pkg::OP_READ, 16'sd0, -16'sd32768, 32'h0);
        send_request(smes_pkg::OP_DELETE, -16'sd32768, -16'sd32768, 32'h0);
        send_request(smes_pkg::OP_UNUSED, 16'sd0, 16'sd0, 32'hDEAD_BEEF);
        send_request(smes_pkg::OP_READ, 16'sd0, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_DELETE, 16'sd0, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_DELETE, 16'sd0, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_READ, 16'sd0, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_READ, 16'sd32767, 16'sd32767, 32'h0);
        send_request(smes_pkg::OP_DELETE, 16'sd32766, 16'sd0, 32'h0);
        send_request(smes_pkg::OP_INSERT, 16'sd5, 16'sd7, 32'h8000_0000);

        set_bounds(15'd0, 15'd1);
        send_request(smes_pkg::OP_READ, 16'sd32766, 16'sd32766, 32'h0);
        send_request(smes_pkg::OP_INSERT, 16'sd0, 16'sd0, 32'h5555_AAAA);
        send_request(smes_pkg::OP_DELETE, 16'sd5, 16'sd7, 32'h0);
        random_requests(5, 4, 40, 30);

        wait_idle();
        write_cfg(CFG_SPARE, 15'd5);
        write_cfg(CFG_LAST, '1);
        random_requests(3, 4, 40, 30);

        set_bounds(BOUND_MAX, 15'd0);
        random_requests(2, 8, 40, 30);

        set_bounds(15'd8, 15'd8);
        random_requests(130, 9, 45, 30);

        set_bounds(15'd20, 15'd20);
        fill_keys(280, 20);
        random_requests(80, 22, 35, 30);

        set_bounds(15'd4, 15'd4);
        random_requests(40, 6, 35, 35);

        set_bounds(15'd1, 15'd1);
        random_requests(15, 2, 35, 35);

        set_bounds(BOUND_MAX, BOUND_MAX);
        random_requests(50, 22, 30, 45);
        random_requests(40, 32767, 40, 30);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d results over %0d bound settings, zero and full range included.",
                 scb.n_checked, n_settings);
        $display("Reads returning stored data: %0d; inserts refused by a full table: %0d.",
                 scb.n_read_hits, scb.n_full);
        if (scb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

[files.f]
rtl/smes_pkg.sv
rtl/smes_in_if.sv
rtl/smes_out_if.sv
rtl/smes_cell.sv
rtl/sparse_matrix_entry_store_top.sv
sim/testbench.sv
